// File: hw/rtl/irt_pkg.sv
// Shared types and constants for the infrared edge pulse/space timer.
`default_nettype none

package irt_pkg;

  // Field widths
  localparam int unsigned DUR_BITS  = 24;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned NRES = 3;

  // Register reset values
  localparam logic [DUR_BITS-1:0]  MERGE_LIMIT_RST = DUR_BITS'(250);
  localparam logic [DUR_BITS-1:0]  SPACE_LIMIT_RST = DUR_BITS'(20000);
  localparam logic [TIME_BITS-1:0] GAP_CLAMP_RST   = TIME_BITS'(16000000);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MERGE_LIMIT = 2'd0,
    CFG_SPACE_LIMIT = 2'd1,
    CFG_GAP_CLAMP   = 2'd2
  } irt_cfg_idx_e;

  // Current register values
  typedef struct packed {
    logic [DUR_BITS-1:0]  merge_limit;
    logic [DUR_BITS-1:0]  space_limit;
    logic [TIME_BITS-1:0] gap_clamp;
  } irt_cfg_t;

  // Timed interval handed from the timer to the filter
  typedef struct packed {
    logic                level;
    logic                gap;
    logic [DUR_BITS-1:0] len;
  } irt_tm_t;

  // One result item
  typedef struct packed {
    logic                is_pulse;
    logic [DUR_BITS-1:0] duration;
    logic                last;
  } irt_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/irt_ifs.sv
// Stream and configuration interfaces of the infrared edge pulse/space timer.
`default_nettype none

interface irt_edge_if import irt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] time_us;
  logic                 level;

  modport source (output valid, output time_us, output level, input ready);
  modport sink   (input valid, input time_us, input level, output ready);
endinterface

interface irt_pulse_if import irt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_pulse;
  logic [DUR_BITS-1:0] duration_us;
  logic                last_of_run;

  modport source (output valid, output is_pulse, output duration_us, output last_of_run,
                  input ready);
  modport sink   (input valid, input is_pulse, input duration_us, input last_of_run,
                  output ready);
endinterface

interface irt_cfg_if import irt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [TIME_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/irt_cfg_regs.sv
// Configuration register file of the infrared edge pulse/space timer.
`default_nettype none

module irt_cfg_regs import irt_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  irt_cfg_if.sink  cfg_i,
  output irt_cfg_t cfg_o
);

  irt_cfg_t cfg_q;
  logic     wr;

  // Always take a write
  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;

  // Decode index, drop writes outside the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_limit <= MERGE_LIMIT_RST;
      cfg_q.space_limit <= SPACE_LIMIT_RST;
      cfg_q.gap_clamp   <= GAP_CLAMP_RST;
    end else if (wr) begin
      unique case (cfg_i.index)
        CFG_MERGE_LIMIT: cfg_q.merge_limit <= cfg_i.data[DUR_BITS-1:0];
        CFG_SPACE_LIMIT: cfg_q.space_limit <= cfg_i.data[DUR_BITS-1:0];
        CFG_GAP_CLAMP:   cfg_q.gap_clamp   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/irt_timer.sv
// Edge timer: spike rejection, elapsed time, saturation and gap detection.
`default_nettype none

module irt_timer import irt_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  irt_edge_if.sink edge_i,
  input  irt_cfg_t cfg_i,
  output logic     tm_valid_o,
  input  wire      tm_ready_i,
  output irt_tm_t  tm_o
);

  logic [TIME_BITS-1:0] prev_time_q;
  logic                 prev_valid_q;
  logic                 prev_level_q;
  logic                 tv_q, tv_d;
  irt_tm_t              tm_q;

  logic                 accept;
  logic                 spike;
  logic                 backwards;
  logic [TIME_BITS-1:0] delta;
  logic                 gap;
  logic                 over;
  logic [DUR_BITS-1:0]  len;

  // Take a beat while the stage is empty or draining
  assign edge_i.ready = !tv_q || tm_ready_i;
  assign accept = edge_i.valid && edge_i.ready;

  // Time the interval ending at this edge
  assign spike     = prev_valid_q && (edge_i.level == prev_level_q);
  assign backwards = edge_i.time_us < prev_time_q;
  assign delta     = edge_i.time_us - prev_time_q;
  assign gap       = !backwards && (delta >= cfg_i.gap_clamp);
  assign over      = |delta[TIME_BITS-1:DUR_BITS];
  assign len       = (backwards || gap || over) ? '1 : delta[DUR_BITS-1:0];

  // Hold the stage until the filter takes it; spikes never enter
  always_comb begin
    tv_d = tv_q;
    if (tm_ready_i) tv_d = 1'b0;
    if (accept && !spike) tv_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q  <= '0;
      prev_valid_q <= 1'b0;
      prev_level_q <= 1'b0;
      tv_q         <= 1'b0;
    end else begin
      tv_q <= tv_d;
      if (accept && !spike) begin
        prev_time_q  <= edge_i.time_us;
        prev_valid_q <= 1'b1;
        prev_level_q <= edge_i.level;
      end
    end
  end

  // Payload of the stage
  always_ff @(posedge clk_i) begin
    if (accept && !spike) begin
      tm_q.level <= edge_i.level;
      tm_q.gap   <= gap;
      tm_q.len   <= len;
    end
  end

  assign tm_valid_o = tv_q;
  assign tm_o       = tm_q;

endmodule

`default_nettype wire

// File: hw/rtl/irt_filter.sv
// Sense tracking, pulse/space noise filter and result buffer.
`default_nettype none

module irt_filter import irt_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        tm_valid_i,
  output logic       tm_ready_o,
  input  irt_tm_t    tm_i,
  input  irt_cfg_t   cfg_i,
  irt_pulse_if.source pulse_o
);

  function automatic logic [DUR_BITS-1:0] sat_add(input logic [DUR_BITS-1:0] a,
                                                  input logic [DUR_BITS-1:0] b);
    logic [DUR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DUR_BITS] ? '1 : s[DUR_BITS-1:0];
  endfunction

  logic                sense_q, sense_d;
  logic                hold_q, hold_d;
  logic [DUR_BITS-1:0] hs_q, hs_d;
  logic [DUR_BITS-1:0] hp_q, hp_d;
  logic [1:0]          cnt_q;
  irt_res_t            res_q [NRES];

  logic                pop;
  logic                take;
  logic                pulse;
  logic [DUR_BITS-1:0] hp_sum;
  logic [DUR_BITS-1:0] hs_sum;
  logic [1:0]          n_res;
  irt_res_t            res_n [NRES];

  // Free once the last buffered result leaves
  assign pop        = pulse_o.valid && pulse_o.ready;
  assign tm_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pulse_o.ready);
  assign take       = tm_valid_i && tm_ready_o;

  assign hp_sum = sat_add(hp_q, tm_i.len);
  assign hs_sum = sat_add(sat_add(hs_q, hp_q), tm_i.len);

  // Flip sense on a long gap, class the interval and run the filter
  always_comb begin
    sense_d = sense_q;
    if (tm_i.gap && (tm_i.level == sense_q)) sense_d = ~sense_q;
    pulse  = tm_i.level == sense_d;
    hold_d = hold_q;
    hs_d   = hs_q;
    hp_d   = hp_q;
    n_res  = 2'd0;
    for (int i = 0; i < NRES; i++) res_n[i] = '0;

    if (pulse) begin
      if (hold_q) begin
        hp_d = hp_sum;
        if (hp_sum > cfg_i.merge_limit) begin
          res_n[0] = '{is_pulse: 1'b0, duration: hs_q, last: 1'b0};
          res_n[1] = '{is_pulse: 1'b1, duration: hp_sum, last: 1'b0};
          n_res  = 2'd2;
          hold_d = 1'b0;
          hp_d   = '0;
        end
      end else begin
        res_n[0] = '{is_pulse: 1'b1, duration: tm_i.len, last: 1'b0};
        n_res = 2'd1;
      end
    end else if (!hold_q) begin
      if (tm_i.len > cfg_i.space_limit) begin
        hs_d   = tm_i.len;
        hold_d = 1'b1;
      end else begin
        res_n[0] = '{is_pulse: 1'b0, duration: tm_i.len, last: 1'b0};
        n_res = 2'd1;
      end
    end else if (tm_i.len > cfg_i.space_limit) begin
      hs_d = hs_sum;
      hp_d = '0;
    end else begin
      res_n[0] = '{is_pulse: 1'b0, duration: hs_q, last: 1'b0};
      res_n[1] = '{is_pulse: 1'b1, duration: hp_q, last: 1'b0};
      res_n[2] = '{is_pulse: 1'b0, duration: tm_i.len, last: 1'b0};
      n_res  = 2'd3;
      hold_d = 1'b0;
      hp_d   = '0;
    end

    // Mark the final result of this edge
    for (int i = 0; i < NRES; i++) begin
      res_n[i].last = (2'(i) + 2'd1) == n_res;
    end
  end

  // Filter state and result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_q <= 1'b1;
      hold_q  <= 1'b0;
      hs_q    <= '0;
      hp_q    <= '0;
      cnt_q   <= 2'd0;
    end else begin
      if (take) begin
        sense_q <= sense_d;
        hold_q  <= hold_d;
        hs_q    <= hs_d;
        hp_q    <= hp_d;
        cnt_q   <= n_res;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Load a fresh run, or advance the buffer by one beat
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < NRES; i++) res_q[i] <= res_n[i];
    end else if (pop) begin
      for (int i = 0; i < NRES - 1; i++) res_q[i] <= res_q[i+1];
    end
  end

  assign pulse_o.valid       = cnt_q != 2'd0;
  assign pulse_o.is_pulse    = res_q[0].is_pulse;
  assign pulse_o.duration_us = res_q[0].duration;
  assign pulse_o.last_of_run = res_q[0].last;

endmodule

`default_nettype wire

// File: hw/rtl/ir_edge_pulse_space_timer_top.sv
// Top level of the infrared edge pulse/space timer.
//
//   channel   dir  payload                              beat taken when
//   edge_i    in   time_us[47:0], level                 valid && ready
//   pulse_o   out  is_pulse, duration_us[23:0], last    valid && ready
//   cfg_i     in   index[1:0], data[47:0]               valid && ready (ready always 1)
//
// An edge is timed in the cycle it is taken and registered; the filter
// consumes it and loads its zero to three results into the result buffer.
// One edge per cycle when each gives at most one result and pulse_o does
// not stall; more results stall the next edge until the last is taken.
// Reset clears the timer and filter state and sets the registers to their
// reset values. Stalls on pulse_o back up through the timer stage to edge_i.
`default_nettype none

module ir_edge_pulse_space_timer_top import irt_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  irt_edge_if.sink    edge_i,
  irt_pulse_if.source pulse_o,
  irt_cfg_if.sink     cfg_i
);

  irt_cfg_t cfg;
  irt_tm_t  tm;
  logic     tm_valid;
  logic     tm_ready;

  irt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  irt_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_i     (edge_i),
    .cfg_i      (cfg),
    .tm_valid_o (tm_valid),
    .tm_ready_i (tm_ready),
    .tm_o       (tm)
  );

  irt_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tm_valid_i (tm_valid),
    .tm_ready_o (tm_ready),
    .tm_i       (tm),
    .cfg_i      (cfg),
    .pulse_o    (pulse_o)
  );

  // A run continues after a beat that is not its last
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_o.valid && pulse_o.ready && !pulse_o.last_of_run |=> pulse_o.valid)
    else $error("result run broken before its last beat");

  // Results within a run alternate between space and pulse
  a_run_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_o.valid && pulse_o.ready && !pulse_o.last_of_run
    |=> pulse_o.is_pulse != $past(pulse_o.is_pulse))
    else $error("result run does not alternate");

  // Edges stall only behind a timed interval waiting for the filter
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !edge_i.ready |-> tm_valid && !tm_ready)
    else $error("edge stalled with no pending interval");

endmodule

`default_nettype wire
